// ----- rtl/assert_macros.svh -----
// assertion helpers used by the frame receiver top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("assertion failed");

`endif

// ----- rtl/dlerx_pkg.sv -----
package dlerx_pkg;

  localparam logic [7:0] CODE_STX     = 8'h02;
  localparam logic [7:0] CODE_ETX     = 8'h03;
  localparam logic [7:0] CODE_DLE     = 8'h10;
  localparam logic [7:0] STUFF_OFFSET = 8'h40;

  localparam int MAX_RESULTS = 63;
  localparam int IDX_W       = 6;
  // wide enough for a length byte plus one
  localparam int LEN_W       = 9;

  typedef enum logic [1:0] {
    PH_WAIT_START = 2'd0,
    PH_BODY       = 2'd1,
    PH_WAIT_CHECK = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CS_RUN   = 2'd0,
    CS_FETCH = 2'd1,
    CS_SHOW  = 2'd2
  } ctl_t;

endpackage

// ----- rtl/dle_stx_frame_receiver_top.sv -----
// DLE/STX/ETX frame receiver with XOR block check.
// rx channel: one raw line byte per item on rx_byte (rx_valid / rx_stall).
// pay channel: one result item per payload byte of an accepted frame, with
//   payload_byte, byte_present, byte_index and last_of_frame; an accepted
//   frame with an empty payload gives a single item with byte_present low.
// Line bytes are taken one per cycle while no frame is being read out.
// Body bytes go into a BODY_BYTES deep buffer with a registered read port.
// After the check byte of a good frame is accepted, rx_stall goes high and
// the payload is read back from the buffer: each payload byte passes a
// fetch state (buffer read into the registered read port) and then a show
// state that offers it; the empty marker is offered in the cycle after the
// check byte; the rx side stays held until the last item has been taken.
// Bad frames produce no items and cost nothing beyond their own bytes.
// While pay_stall is high the current item holds and rx stays stalled.
// Reset returns to waiting for DLE STX and drops any frame in progress;
// the buffer needs no clearing since only bytes of the current frame are read.
`include "assert_macros.svh"

module dle_stx_frame_receiver_top #(
  parameter int BODY_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       pay_valid,
  input  logic       pay_stall,
  output logic [7:0] payload_byte,
  output logic       byte_present,
  output logic [dlerx_pkg::IDX_W-1:0] byte_index,
  output logic       last_of_frame
);

  localparam int CW = $clog2(BODY_BYTES + 1);
  localparam int AW = $clog2(BODY_BYTES);
  localparam int IW = dlerx_pkg::IDX_W;
  localparam int LW = dlerx_pkg::LEN_W;

  dlerx_pkg::phase_t phase, phase_next;
  dlerx_pkg::ctl_t   ctl, ctl_next;
  logic              escape_pending, escape_pending_next;
  logic [CW-1:0]     body_count, body_count_next;
  logic [7:0]        running_check, running_check_next;
  logic [7:0]        first_byte, first_byte_next;
  logic [IW-1:0]     out_idx, out_idx_next;
  logic [IW-1:0]     last_idx, last_idx_next;
  logic              empty_run, empty_run_next;

  logic [7:0]    unst;
  logic [7:0]    chk_x;
  logic          room;
  logic [CW-1:0] plen;
  logic          frame_ok;
  logic          accept_frame;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign unst     = escape_pending ? rx_byte - dlerx_pkg::STUFF_OFFSET : rx_byte;
  assign chk_x    = running_check ^ unst;
  assign room     = body_count < CW'(BODY_BYTES);
  assign plen     = body_count - CW'(1);
  assign frame_ok = (chk_x == 8'd0) && (body_count != '0)
                    && (LW'(body_count) == LW'(first_byte) + LW'(1));

  // line byte handling
  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    body_count_next     = body_count;
    running_check_next  = running_check;
    first_byte_next     = first_byte;
    wr_en               = 1'b0;
    accept_frame        = 1'b0;
    if (ctl == dlerx_pkg::CS_RUN && rx_valid) begin
      if (rx_byte == dlerx_pkg::CODE_DLE) begin
        escape_pending_next = 1'b1;
      end else if (rx_byte == dlerx_pkg::CODE_STX) begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          phase_next          = dlerx_pkg::PH_BODY;
          body_count_next     = '0;
          running_check_next  = 8'd0;
        end
      end else begin
        unique case (phase)
          dlerx_pkg::PH_BODY: begin
            escape_pending_next = 1'b0;
            if (escape_pending && rx_byte == dlerx_pkg::CODE_ETX) begin
              running_check_next = running_check ^ dlerx_pkg::CODE_ETX;
              phase_next         = dlerx_pkg::PH_WAIT_CHECK;
            end else if (room) begin
              running_check_next = chk_x;
              wr_en              = 1'b1;
              body_count_next    = body_count + CW'(1);
              if (body_count == '0) begin
                first_byte_next = unst;
              end
            end else begin
              // buffer full: drop the frame
              phase_next = dlerx_pkg::PH_WAIT_START;
            end
          end
          dlerx_pkg::PH_WAIT_CHECK: begin
            escape_pending_next = 1'b0;
            running_check_next  = chk_x;
            phase_next          = dlerx_pkg::PH_WAIT_START;
            accept_frame        = frame_ok;
          end
          default: ;
        endcase
      end
    end
  end

  // readout control
  always_comb begin
    ctl_next       = ctl;
    out_idx_next   = out_idx;
    last_idx_next  = last_idx;
    empty_run_next = empty_run;
    rx_stall       = 1'b1;
    pay_valid      = 1'b0;
    rd_en          = 1'b0;
    unique case (ctl)
      dlerx_pkg::CS_RUN: begin
        rx_stall = 1'b0;
        if (accept_frame) begin
          out_idx_next   = '0;
          empty_run_next = (plen == '0);
          if (LW'(plen) > LW'(dlerx_pkg::MAX_RESULTS)) begin
            last_idx_next = IW'(dlerx_pkg::MAX_RESULTS - 1);
          end else begin
            last_idx_next = IW'(plen - CW'(1));
          end
          ctl_next = (plen == '0) ? dlerx_pkg::CS_SHOW : dlerx_pkg::CS_FETCH;
        end
      end
      dlerx_pkg::CS_FETCH: begin
        rd_en    = 1'b1;
        ctl_next = dlerx_pkg::CS_SHOW;
      end
      dlerx_pkg::CS_SHOW: begin
        pay_valid = 1'b1;
        if (!pay_stall) begin
          if (last_of_frame) begin
            ctl_next = dlerx_pkg::CS_RUN;
          end else begin
            out_idx_next = out_idx + IW'(1);
            ctl_next     = dlerx_pkg::CS_FETCH;
          end
        end
      end
      default: ctl_next = dlerx_pkg::CS_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= dlerx_pkg::CS_RUN;
    end else begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= dlerx_pkg::PH_WAIT_START;
      escape_pending <= 1'b0;
      body_count     <= '0;
      running_check  <= 8'd0;
    end else begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      body_count     <= body_count_next;
      running_check  <= running_check_next;
    end
  end

  always_ff @(posedge clk) begin
    first_byte <= first_byte_next;
    out_idx    <= out_idx_next;
    last_idx   <= last_idx_next;
    empty_run  <= empty_run_next;
  end

  // payload starts after the length byte
  assign rd_addr = AW'(LW'(out_idx) + LW'(1));

  dlerx_ram #(
    .DEPTH (BODY_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (body_count[AW-1:0]),
    .wr_data (unst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign payload_byte  = empty_run ? 8'd0 : rd_data;
  assign byte_present  = !empty_run;
  assign byte_index    = out_idx;
  assign last_of_frame = empty_run || (out_idx == last_idx);

  `ASSERT_SAME(a_no_rx_during_readout, pay_valid, rx_stall)
  `ASSERT_SAME(a_count_in_range, 1'b1, body_count <= CW'(BODY_BYTES))
  `ASSERT_SAME(a_empty_marker_shape, pay_valid && !byte_present,
               last_of_frame && byte_index == '0)
  `ASSERT_NEXT(a_index_steps, pay_valid && !pay_stall && !last_of_frame,
               ##1 (pay_valid && byte_index == IW'($past(byte_index, 2) + IW'(1))))

endmodule

// ----- rtl/dlerx_ram.sv -----
module dlerx_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
